>>> rtl/slir_pkg.sv
// Shared types and constants for the sorted list insert and read-out block.
package slir_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_READ_ASC  = 2'd1,
		OP_READ_DESC = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROT_DN,
		CELL_ROT_UP
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		cell_op_t op;
		value_t   ins_value;
	} cell_cmd_t;

endpackage

>>> rtl/slir_cell.sv
// One storage cell of the sorted chain: insert-shift and rotate in either direction.
module slir_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  slir_pkg::cell_cmd_t cmd,
	input  logic              prev_valid,
	input  logic              prev_less,
	input  slir_pkg::value_t  prev_value,
	input  logic              next_valid,
	input  slir_pkg::value_t  next_value,
	input  slir_pkg::value_t  wrap_value,
	output logic              valid,
	output logic              less,
	output logic              top,
	output slir_pkg::value_t  value
);
	import slir_pkg::*;

	logic   valid_q;
	value_t value_q;

	assign valid = valid_q;
	assign value = value_q;
	assign less  = valid_q && (value_q < cmd.ins_value);
	assign top   = valid_q && !next_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.op == CELL_INSERT && !less && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				// take the new word where the smaller run ends, else shift up
				if (!less && prev_valid) begin
					value_q <= prev_less ? cmd.ins_value : prev_value;
				end
			end
			CELL_ROT_DN: begin
				if (valid_q) begin
					value_q <= top ? wrap_value : next_value;
				end
			end
			CELL_ROT_UP: begin
				if (valid_q) begin
					value_q <= prev_value;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/slir_ctrl.sv
// Sequencer: input handshake, entry count, read-out walk and output register.
module slir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // [31:0] value
	input  logic [1:0]          s_tuser,   // [1:0] operation
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,   // [31:0] result_value
	output logic                m_tlast,
	output logic [1:0]          m_tuser,   // [1:0] status
	input  slir_pkg::value_t    head_asc,
	input  slir_pkg::value_t    head_desc,
	output slir_pkg::cell_cmd_t cmd
);
	import slir_pkg::*;

	state_t  state_q, state_d;
	count_t  count_q, count_d;
	count_t  rem_q, rem_d;
	logic    desc_q, desc_d;
	logic    out_valid_q;
	value_t  out_value_q;
	logic    out_last_q;
	status_t out_status_q;

	logic    slot_free;
	logic    accept;
	logic    full;
	logic    load;
	value_t  load_value;
	logic    load_last;
	status_t load_status;
	value_t  in_value;

	assign slot_free = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign full      = (count_q == count_t'(CAPACITY));
	assign in_value  = value_t'(s_tdata);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		rem_d         = rem_q;
		desc_d        = desc_q;
		s_tready      = 1'b0;
		load          = 1'b0;
		load_value    = in_value;
		load_last     = 1'b1;
		load_status   = STAT_OK;
		cmd.op        = CELL_HOLD;
		cmd.ins_value = in_value;
		case (state_q)
			S_IDLE: begin
				s_tready = slot_free;
				if (accept) begin
					case (s_tuser)
						OP_INSERT: begin
							load = 1'b1;
							if (full) begin
								load_status = STAT_FULL;
							end else begin
								cmd.op  = CELL_INSERT;
								count_d = count_q + count_t'(1);
							end
						end
						OP_READ_ASC, OP_READ_DESC: begin
							if (count_q == '0) begin
								load        = 1'b1;
								load_value  = '0;
								load_status = STAT_EMPTY;
							end else begin
								state_d = S_READ;
								rem_d   = count_q;
								desc_d  = (s_tuser == OP_READ_DESC);
							end
						end
						default: begin
							// unused code: drop the word
						end
					endcase
				end
			end
			S_READ: begin
				if (slot_free) begin
					load       = 1'b1;
					load_value = desc_q ? head_desc : head_asc;
					load_last  = (rem_q == count_t'(1));
					cmd.op     = desc_q ? CELL_ROT_UP : CELL_ROT_DN;
					rem_d      = rem_q - count_t'(1);
					if (rem_q == count_t'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			desc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			desc_q  <= desc_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q  <= load_value;
			out_last_q   <= load_last;
			out_status_q <= load_status;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(CAPACITY))
		else $error("entry count beyond capacity");

	a_no_input_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !s_tready)
		else $error("input taken during read-out");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> rem_q != '0 && rem_q <= count_q)
		else $error("read-out counter out of range");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == OP_INSERT && !full |=> count_q == $past(count_q) + count_t'(1))
		else $error("insert did not advance entry count");

	a_read_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> count_q == $past(count_q))
		else $error("entry count changed during read-out");
`endif

endmodule

>>> rtl/sorted_list_insert_readout.sv
// Top level: chain of sorted storage cells with its sequencer.
// Keeps up to 16 signed 32-bit values in ascending order in a row of cells.
// On an insert (tuser 0) every cell compares its entry with the
// new value at once and the larger and equal entries shift up one cell, so
// one result word (the value, status ok or full) follows each insert. A read
// (tuser 1 ascending, 2 descending) is taken, then rotates the
// chain one step per cycle and emits one entry per cycle, one word per
// entry with tlast on the final one; a step waits while a stalled result
// holds the output register. No input word is taken until the read-out is
// done, and the list comes back to its original order. A read of an empty
// list gives one word with status empty. Operation code 3 is dropped without
// a result. The output register lets a new input word be taken in the cycle
// the last result leaves, but not while it waits.
module sorted_list_insert_readout (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_value
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // [1:0] status
);
	import slir_pkg::*;

	cell_cmd_t cmd;
	logic      valid_w [CAPACITY];
	logic      less_w  [CAPACITY];
	logic      top_w   [CAPACITY];
	value_t    value_w [CAPACITY];
	value_t    head_asc;
	value_t    head_desc;

	assign head_asc = value_w[0];

	// pick the entry of the highest valid cell
	always_comb begin
		head_desc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			head_desc = head_desc | (top_w[i] ? value_w[i] : value_t'(0));
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic   pv;
		logic   pl;
		value_t pval;
		logic   nv;
		value_t nval;

		if (g == 0) begin : g_first
			assign pv   = 1'b1;
			assign pl   = 1'b1;
			assign pval = head_desc;
		end else begin : g_mid
			assign pv   = valid_w[g-1];
			assign pl   = less_w[g-1];
			assign pval = value_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign nv   = 1'b0;
			assign nval = '0;
		end else begin : g_inner
			assign nv   = valid_w[g+1];
			assign nval = value_w[g+1];
		end

		slir_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (pv),
			.prev_less  (pl),
			.prev_value (pval),
			.next_valid (nv),
			.next_value (nval),
			.wrap_value (head_asc),
			.valid      (valid_w[g]),
			.less       (less_w[g]),
			.top        (top_w[g]),
			.value      (value_w[g])
		);
	end

	slir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.head_asc  (head_asc),
		.head_desc (head_desc),
		.cmd       (cmd)
	);

endmodule

>>> dv/slir_list_checker.sv
// Checker for the sorted list block: tracks the list, predicts every result word and compares.
`timescale 1ns / 1ps

module slir_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] result_value
	input  logic        m_tlast,
	input  logic [1:0]  m_tuser,   // [1:0] status
	output int          mismatches,
	output int          outstanding
);
	import slir_pkg::*;

	typedef struct packed {
		value_t  val;
		logic    last;
		status_t stat;
	} result_word_t;

	value_t       list_entries [CAPACITY];
	int           list_count;
	result_word_t due_results [$];

	// Apply one accepted word to the list copy and queue the words it should cause.
	task automatic list_step(input logic [1:0] op, input value_t v);
		int pos;
		int i;
		int idx;
		case (op)
			OP_INSERT: begin
				if (list_count >= CAPACITY) begin
					due_results.push_back('{val: v, last: 1'b1, stat: STAT_FULL});
				end else begin
					// place after every strictly smaller entry, so equal values stay together
					pos = 0;
					while (pos < list_count && list_entries[pos] < v)
						pos++;
					for (i = list_count; i > pos; i--)
						list_entries[i] = list_entries[i-1];
					list_entries[pos] = v;
					list_count++;
					due_results.push_back('{val: v, last: 1'b1, stat: STAT_OK});
				end
			end
			OP_READ_ASC, OP_READ_DESC: begin
				if (list_count == 0) begin
					due_results.push_back('{val: '0, last: 1'b1, stat: STAT_EMPTY});
				end else begin
					for (i = 0; i < list_count; i++) begin
						idx = (op == OP_READ_ASC) ? i : list_count - 1 - i;
						due_results.push_back('{val: list_entries[idx],
							last: logic'(i == list_count - 1), stat: STAT_OK});
					end
				end
			end
			default: ;  // unused code: drop silently
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t got;
		result_word_t want;
		if (!arst_n) begin
			list_count = 0;
			due_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				list_step(s_tuser, value_t'(s_tdata));
			if (m_tvalid && m_tready) begin
				got = '{val: value_t'(m_tdata), last: m_tlast, stat: status_t'(m_tuser)};
				if (due_results.size() == 0) begin
					$display("%0t: unexpected word: value %0d last %0b status %0d",
						$time, got.val, got.last, got.stat);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (got.val !== want.val || got.last !== want.last ||
					    got.stat !== want.stat) begin
						$display({"%0t: expected value %0d last %0b status %0d, ",
							"got value %0d last %0b status %0d"},
							$time, want.val, want.last, want.stat,
							got.val, got.last, got.stat);
						mismatches++;
					end
				end
			end
			outstanding = due_results.size();
		end
	end

endmodule

>>> dv/tb_sorted_list_insert_readout.sv
// Testbench top for the sorted list block: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_sorted_list_insert_readout;
	import slir_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [31:0] value
	logic [1:0]  s_tuser;    // [1:0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [31:0] result_value
	logic        m_tlast;
	logic [1:0]  m_tuser;    // [1:0] status
	int          mismatches;
	int          outstanding;
	bit          no_gaps;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sorted_list_insert_readout dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	slir_list_checker list_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one word after a random gap; return at the edge where it is taken.
	task automatic send_word(input logic [1:0] op, input value_t v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= v;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_word();
		int         r;
		logic [1:0] op;
		value_t     v;
		r = $urandom_range(0, 99);
		if (r < 30)
			op = OP_INSERT;
		else if (r < 60)
			op = OP_READ_ASC;
		else if (r < 90)
			op = OP_READ_DESC;
		else
			op = OP_UNUSED;
		// narrow values give plenty of duplicates, wide ones exercise every bit
		case ($urandom_range(0, 3))
			0: v = value_t'(int'($urandom_range(0, 8)) - 4);
			1: v = value_t'($urandom);
			2: v = 32'h8000_0000 + value_t'($urandom_range(0, 3));
			default: v = 32'h7fff_ffff - value_t'($urandom_range(0, 3));
		endcase
		send_word(op, v);
	endtask

	// Result side: stall a random number of cycles before each word.
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		int c;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_INSERT;
		no_gaps  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty list, unused code, extremes and duplicates
		send_word(OP_READ_ASC, 32'h1234_5678);
		send_word(OP_READ_DESC, 32'hffff_ffff);
		send_word(OP_UNUSED, 32'h5a5a_a5a5);
		send_word(OP_INSERT, 32'h0000_0000);
		send_word(OP_READ_ASC, 32'h0);
		send_word(OP_INSERT, 32'h7fff_ffff);
		send_word(OP_INSERT, 32'h8000_0000);
		send_word(OP_INSERT, 32'hffff_ffff);
		send_word(OP_INSERT, 32'h0000_0001);
		send_word(OP_INSERT, 32'h0000_0005);
		send_word(OP_UNUSED, 32'h0000_0007);
		send_word(OP_INSERT, 32'h0000_0005);
		send_word(OP_INSERT, 32'hffff_ffff);
		send_word(OP_INSERT, 32'h7fff_ffff);
		send_word(OP_READ_ASC, 32'ha5a5_5a5a);
		send_word(OP_READ_DESC, 32'h0);
		send_word(OP_INSERT, 32'h8000_0000);
		send_word(OP_INSERT, 32'h0000_0000);
		send_word(OP_READ_DESC, 32'h0);

		// random traffic; the third phase runs with no idling on either side
		for (int p = 0; p < 4; p++) begin
			no_gaps = (p == 2);
			for (int k = 0; k < 23; k++)
				random_word();
		end
		s_tvalid <= 1'b0;
		no_gaps = 1'b0;

		// let the checker see the final accepted word before draining
		@(posedge clk);
		for (c = 0; c < 4000 && outstanding != 0; c++)
			@(posedge clk);
		if (outstanding != 0)
			$display("%0t: %0d result words never arrived", $time, outstanding);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("** sorted_list_insert_readout: PASSED **");
		else
			$display("** sorted_list_insert_readout: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** sorted_list_insert_readout: FAILED **");
		$finish;
	end

endmodule
